[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_IMPL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[design/fnvkh_pkg.sv]
// ----------------------------------------------------------------------------
// fnvkh_pkg
// Types, constants and the FNV byte step shared by the keyed hash log.
// ----------------------------------------------------------------------------
package fnvkh_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;

  localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
  // The prime is 2^40 + 0x1b3, so a multiply is a shift plus a narrow product.
  localparam int unsigned FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1b3;
  localparam logic [63:0] GOLDEN          = 64'h9e3779b97f4a7c15;
  localparam logic [7:0]  IPAD            = 8'h36;
  localparam logic [7:0]  OPAD            = 8'h5c;

  localparam int unsigned NUM_SECRET  = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned IN_TDATA_W  = 208;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 264;
  localparam int unsigned OUT_TUSER_W = 1;

  localparam logic       ACT_APPEND = 1'b0;
  localparam logic       ACT_LOCATE = 1'b1;
  localparam logic [1:0] KIND_NULL  = 2'd0;
  localparam logic [1:0] KIND_BOOL  = 2'd1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TAG,
    ST_BOOL,
    ST_VAL,
    ST_SAVE,
    ST_KEYI,
    ST_PLOAD,
    ST_PREV,
    ST_SLOAD,
    ST_STATE,
    ST_TICK,
    ST_VER,
    ST_NONCE,
    ST_SAVEI,
    ST_KEYO,
    ST_INNER,
    ST_DONE,
    ST_SEARCH
  } state_e;

  typedef enum logic [3:0] {
    SRC_TAG,
    SRC_BOOL,
    SRC_VAL,
    SRC_KEY_I,
    SRC_KEY_O,
    SRC_DIG,
    SRC_TICK,
    SRC_VER,
    SRC_NONCE,
    SRC_INNER
  } src_e;

  typedef enum logic [1:0] {
    HOP_HOLD,
    HOP_MIX,
    HOP_BASIS
  } hop_e;

  typedef struct packed {
    logic       in_load;
    hop_e       hop;
    src_e       src;
    logic [4:0] idx;
    logic       save_state;
    logic       dig_load_prev;
    logic       dig_load_state;
    logic       save_inner;
    logic       srch_run;
    logic       commit_app;
    logic       commit_loc;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic hit;
    logic miss;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FNV_PRIME_SHIFT) + (x * {55'd0, FNV_PRIME_LOW});
  endfunction

endpackage

[design/fnvkh_ctrl.sv]
// ----------------------------------------------------------------------------
// fnvkh_ctrl
// Sequencer that walks the byte phases of an append and runs a locate.
// ----------------------------------------------------------------------------
module fnvkh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_action_i,
  input  logic [1:0]         in_kind_i,
  output logic               in_ready_o,
  input  fnvkh_pkg::sts_t    sts_i,
  output fnvkh_pkg::cmd_t    cmd_o
);
  import fnvkh_pkg::*;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] kind_q, kind_d;
  logic       last2, last8, last32;

  assign last2  = cnt_q[0];
  assign last8  = (cnt_q[2:0] == 3'd7);
  assign last32 = (cnt_q == 5'd31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      kind_q  <= KIND_NULL;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.idx  = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          cmd_o.hop     = HOP_BASIS;
          cnt_d         = '0;
          kind_d        = in_kind_i;
          state_d       = (in_action_i == ACT_LOCATE) ? ST_SEARCH : ST_TAG;
        end
      end
      ST_TAG: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_TAG;
        cnt_d     = last2 ? 5'd0 : cnt_q + 5'd1;
        if (last2) begin
          priority if (kind_q == KIND_NULL) begin
            state_d = ST_SAVE;
          end else if (kind_q == KIND_BOOL) begin
            state_d = ST_BOOL;
          end else begin
            state_d = ST_VAL;
          end
        end
      end
      ST_BOOL: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_BOOL;
        state_d   = ST_SAVE;
      end
      ST_VAL: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_VAL;
        cnt_d     = last8 ? 5'd0 : cnt_q + 5'd1;
        if (last8) state_d = ST_SAVE;
      end
      ST_SAVE: begin
        // The value hash is kept and the working hash restarts for the signature.
        cmd_o.save_state = 1'b1;
        cmd_o.hop        = HOP_BASIS;
        state_d          = sts_i.key_zero ? ST_DONE : ST_KEYI;
      end
      ST_KEYI: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_KEY_I;
        cnt_d     = last32 ? 5'd0 : cnt_q + 5'd1;
        if (last32) state_d = ST_PLOAD;
      end
      ST_PLOAD: begin
        cmd_o.dig_load_prev = 1'b1;
        state_d             = ST_PREV;
      end
      ST_PREV: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_DIG;
        cnt_d     = last32 ? 5'd0 : cnt_q + 5'd1;
        if (last32) state_d = ST_SLOAD;
      end
      ST_SLOAD: begin
        cmd_o.dig_load_state = 1'b1;
        state_d              = ST_STATE;
      end
      ST_STATE: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_DIG;
        cnt_d     = last32 ? 5'd0 : cnt_q + 5'd1;
        if (last32) state_d = ST_TICK;
      end
      ST_TICK: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_TICK;
        cnt_d     = last8 ? 5'd0 : cnt_q + 5'd1;
        if (last8) state_d = ST_VER;
      end
      ST_VER: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_VER;
        cnt_d     = last8 ? 5'd0 : cnt_q + 5'd1;
        if (last8) state_d = ST_NONCE;
      end
      ST_NONCE: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_NONCE;
        cnt_d     = last8 ? 5'd0 : cnt_q + 5'd1;
        if (last8) state_d = ST_SAVEI;
      end
      ST_SAVEI: begin
        cmd_o.save_inner = 1'b1;
        cmd_o.hop        = HOP_BASIS;
        state_d          = ST_KEYO;
      end
      ST_KEYO: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_KEY_O;
        cnt_d     = last32 ? 5'd0 : cnt_q + 5'd1;
        if (last32) state_d = ST_INNER;
      end
      ST_INNER: begin
        cmd_o.hop = HOP_MIX;
        cmd_o.src = SRC_INNER;
        cnt_d     = last8 ? 5'd0 : cnt_q + 5'd1;
        if (last8) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit_app = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_SEARCH: begin
        if (sts_i.hit || sts_i.miss) begin
          if (sts_i.out_free) begin
            cmd_o.commit_loc = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          cmd_o.srch_run = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[design/fnvkh_dp.sv]
// ----------------------------------------------------------------------------
// fnvkh_dp
// Hash datapath: one FNV byte unit, key and chain registers, tick ring.
// ----------------------------------------------------------------------------
module fnvkh_dp #(
  parameter int unsigned RING_DEPTH = fnvkh_pkg::RING_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fnvkh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [63:0]                          cfg_data_i,
  input  logic [fnvkh_pkg::IN_TDATA_W-1:0]     in_tdata_i,
  input  fnvkh_pkg::cmd_t                      cmd_i,
  output fnvkh_pkg::sts_t                      sts_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [fnvkh_pkg::OUT_TDATA_W-1:0]    out_tdata_o,
  output logic [fnvkh_pkg::OUT_TUSER_W-1:0]    out_tuser_o
);
  import fnvkh_pkg::*;

  localparam int unsigned SlotW = $clog2(RING_DEPTH);
  localparam int unsigned CntW  = $clog2(RING_DEPTH + 1);

  logic [63:0]      secret_q [NUM_SECRET];
  logic [255:0]     key;
  logic [15:0]      tag_q;
  logic [63:0]      val_q, tick_q, ver_q;
  logic [63:0]      h_q, state_q, inner_q, w_q;
  logic             dig_pres_q;
  logic [63:0]      nonce_q, last_q;
  logic [SlotW-1:0] wslot_q, ptr_q, pend_addr_q;
  logic [CntW-1:0]  fill_q, k_q;
  logic             pend_q;
  logic [63:0]      rd_q;
  logic [63:0]      ring_q [RING_DEPTH];

  logic             out_valid_q, out_found_q;
  logic [63:0]      out_state_q, out_prev_q, out_sig_q, out_nonce_q;
  logic [5:0]       out_slot_q;

  logic             have_prev, full, re;
  logic [7:0]       mix_byte;
  logic [SlotW-1:0] slot_sel;
  logic [SlotW+5:0] slot_ext;

  assign key       = {secret_q[3], secret_q[2], secret_q[1], secret_q[0]};
  assign have_prev = (fill_q != '0);
  assign full      = (fill_q == CntW'(RING_DEPTH));
  assign re        = cmd_i.srch_run && (k_q != fill_q);

  always_comb begin
    unique case (cmd_i.src)
      SRC_TAG:   mix_byte = tag_q[{cmd_i.idx[0], 3'b000} +: 8];
      SRC_BOOL:  mix_byte = {7'd0, |val_q};
      SRC_VAL:   mix_byte = val_q[{cmd_i.idx[2:0], 3'b000} +: 8];
      SRC_KEY_I: mix_byte = key[{cmd_i.idx, 3'b000} +: 8] ^ IPAD;
      SRC_KEY_O: mix_byte = key[{cmd_i.idx, 3'b000} +: 8] ^ OPAD;
      SRC_DIG:   mix_byte = w_q[{cmd_i.idx[2:0], 3'b000} +: 8];
      SRC_TICK:  mix_byte = tick_q[{cmd_i.idx[2:0], 3'b000} +: 8];
      SRC_VER:   mix_byte = ver_q[{cmd_i.idx[2:0], 3'b000} +: 8];
      SRC_NONCE: mix_byte = nonce_q[{cmd_i.idx[2:0], 3'b000} +: 8];
      SRC_INNER: mix_byte = inner_q[{cmd_i.idx[2:0], 3'b000} +: 8];
      default:   mix_byte = '0;
    endcase
  end

  // Append reports the slot it writes; a locate hit reports the matching slot.
  assign slot_sel = cmd_i.commit_app ? wslot_q : (sts_o.hit ? pend_addr_q : '0);
  assign slot_ext = {6'd0, slot_sel};

  assign sts_o.key_zero = (key == '0);
  assign sts_o.hit      = pend_q && (rd_q == tick_q);
  assign sts_o.miss     = !pend_q && (k_q == fill_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SECRET; i++) secret_q[i] <= '0;
      nonce_q     <= '0;
      last_q      <= '0;
      wslot_q     <= '0;
      fill_q      <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) secret_q[cfg_idx_i] <= cfg_data_i;
      if (cmd_i.save_state) nonce_q <= nonce_q + 64'd1;
      if (cmd_i.in_load) begin
        k_q    <= '0;
        pend_q <= 1'b0;
      end else if (cmd_i.srch_run) begin
        pend_q <= re;
        if (re) k_q <= k_q + CntW'(1);
      end
      if (cmd_i.commit_app) begin
        last_q  <= state_q;
        wslot_q <= (wslot_q == SlotW'(RING_DEPTH - 1)) ? '0 : wslot_q + SlotW'(1);
        if (!full) fill_q <= fill_q + CntW'(1);
      end
      if (cmd_i.commit_app || cmd_i.commit_loc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      tag_q  <= in_tdata_i[15:0];
      val_q  <= in_tdata_i[79:16];
      tick_q <= in_tdata_i[143:80];
      ver_q  <= in_tdata_i[207:144];
      // The oldest held tick sits at slot zero until the ring has wrapped.
      ptr_q  <= full ? wslot_q : '0;
    end else if (re) begin
      ptr_q  <= (ptr_q == SlotW'(RING_DEPTH - 1)) ? '0 : ptr_q + SlotW'(1);
    end
    if (re) pend_addr_q <= ptr_q;

    unique case (cmd_i.hop)
      HOP_MIX:   h_q <= fnv_mix(h_q, mix_byte);
      HOP_BASIS: h_q <= FNV_BASIS;
      default:   h_q <= h_q;
    endcase
    if (cmd_i.save_state) state_q <= h_q;
    if (cmd_i.save_inner) inner_q <= h_q;

    if (cmd_i.dig_load_prev) begin
      w_q        <= have_prev ? last_q : '0;
      dig_pres_q <= have_prev;
    end else if (cmd_i.dig_load_state) begin
      w_q        <= state_q;
      dig_pres_q <= 1'b1;
    end else if (cmd_i.hop == HOP_MIX && cmd_i.src == SRC_DIG && cmd_i.idx[2:0] == 3'd7) begin
      w_q <= w_q + (dig_pres_q ? GOLDEN : 64'd0);
    end

    if (cmd_i.commit_app) begin
      out_state_q <= state_q;
      out_prev_q  <= have_prev ? last_q : '0;
      out_sig_q   <= sts_o.key_zero ? '0 : h_q;
      out_nonce_q <= nonce_q;
      out_found_q <= 1'b0;
      out_slot_q  <= slot_ext[5:0];
    end else if (cmd_i.commit_loc) begin
      out_state_q <= '0;
      out_prev_q  <= '0;
      out_sig_q   <= '0;
      out_nonce_q <= '0;
      out_found_q <= sts_o.hit;
      out_slot_q  <= slot_ext[5:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_app) ring_q[wslot_q] <= tick_q;
    if (re) rd_q <= ring_q[ptr_q];
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {2'b00, out_slot_q, out_nonce_q, out_sig_q, out_prev_q, out_state_q};
  assign out_tuser_o = out_found_q;

endmodule

[design/fnv_keyed_hash_chain_log_unit.sv]
// ----------------------------------------------------------------------------
// fnv_keyed_hash_chain_log_unit
// Keyed FNV-1a hash-chained log with a ring of ticks and a tick search.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: action, value_kind; tdata: tag, value, tick, version
//  m_axis    out        tuser: found; tdata: digest, prev, signature, nonce, slot
//  cfg       in         secret_word0..3, one 64-bit word per write
//
// An append hashes one FNV byte step per cycle through the single shift-and-multiply
// unit; with an all-zero key the signature phases are skipped. A locate walks the
// ring from the oldest held tick, one ring read per cycle, until a match or until
// every filled slot has been read.
// Reset clears the chain state at once; ring slots are read only after written.
// A stalled output holds its beat while the next input beat is taken; the unit
// then waits at its finish until the output register frees.
`include "assert_macros.svh"

module fnv_keyed_hash_chain_log_unit #(
  parameter int unsigned RING_DEPTH = fnvkh_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fnvkh_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [63:0]                        cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // type_tag[15:0], value_bits[79:16], tick[143:80], version[207:144]
  input  logic [fnvkh_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // action[0], value_kind[2:1]
  input  logic [fnvkh_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // state_digest[63:0], prev_digest[127:64], signature[191:128],
  // nonce_used[255:192], slot_index[261:256], zero fill[263:262]
  output logic [fnvkh_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // found[0]
  output logic [fnvkh_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);
  import fnvkh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fnvkh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser[0]),
    .in_kind_i   (s_axis_tuser[2:1]),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fnvkh_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_tdata_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser)
  );

  `ASSERT_NEVER(a_commit_over_result, (cmd.commit_app || cmd.commit_loc) && m_axis_tvalid && !m_axis_tready, "result committed over a beat still waiting")
  `ASSERT_IMPL(a_locate_hit_fields, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[255:0] == '0, "locate hit carries nonzero hash fields")
  `ASSERT_IMPL(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken again right after a beat")

endmodule
